>>> design/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and constants of the learning switch forwarder.
// ----------------------------------------------------------------------------
package lsf_pkg;

	localparam int NUM_PORTS  = 8;
	localparam int ADDR_COUNT = 1024;
	localparam int ADDR_W     = $clog2(ADDR_COUNT);

	localparam int PORT_W  = 3;
	localparam int NADDR_W = 10;
	localparam int MASK_W  = 8;
	localparam int TAG_W   = 16;
	localparam int IDX_W   = 2;
	localparam int CDATA_W = 10;

	localparam logic [NADDR_W-1:0] NO_LEARN_RESET = NADDR_W'(1000);

	typedef enum logic [IDX_W-1:0] {
		REG_PORT_ENABLE   = 2'd0,
		REG_MIN_HOST_ADDR = 2'd1,
		REG_NO_LEARN_ADDR = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [MASK_W-1:0]  port_enable;
		logic [NADDR_W-1:0] min_host_addr;
		logic [NADDR_W-1:0] no_learn_addr;
	} cfg_t;

	typedef struct packed {
		logic              vld;
		logic [PORT_W-1:0] port;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
	} tbl_wr_t;

	// ports that exist on the switch and fit in the forward mask
	function automatic logic [MASK_W-1:0] exist_mask();
		logic [MASK_W-1:0] m;
		m = '0;
		for (int i = 0; i < MASK_W; i++) begin
			m[i] = (i < NUM_PORTS);
		end
		return m;
	endfunction

endpackage

>>> design/lsf_cfg.sv
// ----------------------------------------------------------------------------
// lsf_cfg
// Configuration registers, written through the register write channel.
// ----------------------------------------------------------------------------
module lsf_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [lsf_pkg::IDX_W-1:0]    wr_index,
	input  logic [lsf_pkg::CDATA_W-1:0]  wr_data,
	output lsf_pkg::cfg_t                cfg
);

	lsf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.port_enable   <= '1;
			cfg_q.min_host_addr <= '0;
			cfg_q.no_learn_addr <= lsf_pkg::NO_LEARN_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				lsf_pkg::REG_PORT_ENABLE:
					cfg_q.port_enable <= wr_data[lsf_pkg::MASK_W-1:0];
				lsf_pkg::REG_MIN_HOST_ADDR:
					cfg_q.min_host_addr <= wr_data[lsf_pkg::NADDR_W-1:0];
				lsf_pkg::REG_NO_LEARN_ADDR:
					cfg_q.no_learn_addr <= wr_data[lsf_pkg::NADDR_W-1:0];
				default: ; // unused index, write ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/lsf_addr_table.sv
// ----------------------------------------------------------------------------
// lsf_addr_table
// Address table memory: one write and one registered read per cycle, with a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module lsf_addr_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lsf_pkg::tbl_wr_t            wr,
	input  logic                        rd_en,
	input  logic [lsf_pkg::ADDR_W-1:0]  rd_addr,
	output lsf_pkg::entry_t             rd_data,
	output logic                        busy
);

	lsf_pkg::entry_t mem [lsf_pkg::ADDR_COUNT];
	lsf_pkg::entry_t rd_q;
	logic [lsf_pkg::ADDR_W-1:0] clr_q;
	logic clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == lsf_pkg::ADDR_W'(lsf_pkg::ADDR_COUNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr] <= '{vld: 1'b1, port: wr.port};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign busy    = clr_busy_q;

endmodule

>>> design/learning_switch_forwarder_core.sv
// ----------------------------------------------------------------------------
// learning_switch_forwarder_core
// Learning bridge: learns source ports and forwards or floods each header.
//
// channel  direction  beat contents (low bits first)
// s_axis   in         in_port[2:0] src_addr[12:3] dst_addr[22:13] packet_tag[38:23]
// m_axis   out        forward_mask[7:0] dropped[8] was_flooded[9] out_tag[25:10]
// cfg      in         cfg_index selects register, cfg_data carries the value
//
// One header per cycle while m_axis does not stall; each header passes through
// stage 1 and the result register before it is offered on m_axis. The table
// read is issued on the input beat, the learn write goes out as the header
// leaves the first stage, with a bypass between neighbours.
// After reset the table is swept clear with s_axis_tready low. A stall on
// m_axis holds both stages in place.
// ----------------------------------------------------------------------------
module learning_switch_forwarder_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// in_port, src_addr, dst_addr, packet_tag, zero pad
	input  logic [39:0]                 s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// forward_mask, dropped, was_flooded, out_tag, zero pad
	output logic [31:0]                 m_axis_tdata,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lsf_pkg::IDX_W-1:0]   cfg_index,
	input  logic [lsf_pkg::CDATA_W-1:0] cfg_data
);

	lsf_pkg::cfg_t    cfg;
	lsf_pkg::tbl_wr_t tbl_wr;
	lsf_pkg::entry_t  rd_data;
	logic tbl_busy;

	logic [lsf_pkg::PORT_W-1:0]  in_port;
	logic [lsf_pkg::NADDR_W-1:0] in_src, in_dst;
	logic [lsf_pkg::TAG_W-1:0]   in_tag;
	logic in_acc, adv_s1;

	logic                        valid_s1;
	logic [lsf_pkg::PORT_W-1:0]  port_s1;
	logic [lsf_pkg::NADDR_W-1:0] src_s1, dst_s1;
	logic [lsf_pkg::TAG_W-1:0]   tag_s1;
	logic                        byp_hit_s1;
	logic [lsf_pkg::PORT_W-1:0]  byp_port_s1;

	logic drop, learn, dst_in_range, known;
	logic [lsf_pkg::PORT_W-1:0] hit_port;
	logic [lsf_pkg::MASK_W-1:0] mask;
	logic flood;

	logic                       out_valid_q;
	logic [lsf_pkg::MASK_W-1:0] out_mask_q;
	logic                       out_drop_q, out_flood_q;
	logic [lsf_pkg::TAG_W-1:0]  out_tag_q;

	assign in_port = s_axis_tdata[2:0];
	assign in_src  = s_axis_tdata[12:3];
	assign in_dst  = s_axis_tdata[22:13];
	assign in_tag  = s_axis_tdata[38:23];

	assign cfg_ready = 1'b1;

	lsf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lsf_addr_table u_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_en   (in_acc),
		.rd_addr (lsf_pkg::ADDR_W'(in_dst)),
		.rd_data (rd_data),
		.busy    (tbl_busy)
	);

	assign adv_s1        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !tbl_busy && (!valid_s1 || adv_s1);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// decision for the header in stage 1
	always_comb begin
		drop = src_s1 < cfg.min_host_addr;
		learn = !drop && (src_s1 != cfg.no_learn_addr)
			&& (32'(src_s1) < lsf_pkg::ADDR_COUNT)
			&& (32'(port_s1) < lsf_pkg::NUM_PORTS);
		dst_in_range = 32'(dst_s1) < lsf_pkg::ADDR_COUNT;
		known = 1'b0;
		hit_port = rd_data.port;
		mask = '0;
		flood = 1'b0;
		priority if (drop) begin
			known = 1'b0;
		end else if (learn && (src_s1 == dst_s1)) begin
			// sent back to its own sender
			known = 1'b1;
			hit_port = port_s1;
		end else if (dst_in_range && byp_hit_s1) begin
			// neighbour wrote this entry on the same edge as the read
			known = 1'b1;
			hit_port = byp_port_s1;
		end else if (dst_in_range && rd_data.vld) begin
			known = 1'b1;
			hit_port = rd_data.port;
		end else begin
			known = 1'b0;
		end
		if (!drop) begin
			if (known) begin
				mask = lsf_pkg::MASK_W'(1) << hit_port;
			end else begin
				flood = 1'b1;
				mask = cfg.port_enable & lsf_pkg::exist_mask()
					& ~(lsf_pkg::MASK_W'(1) << port_s1);
			end
		end
	end

	assign tbl_wr.en   = valid_s1 && adv_s1 && learn;
	assign tbl_wr.addr = lsf_pkg::ADDR_W'(src_s1);
	assign tbl_wr.port = port_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			port_s1     <= in_port;
			src_s1      <= in_src;
			dst_s1      <= in_dst;
			tag_s1      <= in_tag;
			byp_hit_s1  <= tbl_wr.en && (src_s1 == in_dst);
			byp_port_s1 <= port_s1;
		end
		if (adv_s1 && valid_s1) begin
			out_mask_q  <= mask;
			out_drop_q  <= drop;
			out_flood_q <= flood;
			out_tag_q   <= tag_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_tag_q, out_flood_q, out_drop_q, out_mask_q};

`ifndef SYNTHESIS
	// no header taken while the table is being swept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !tbl_busy)
		else $error("header accepted during table clear");

	// learning never collides with the clearing sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr.en |-> !tbl_busy)
		else $error("table write during clear");

	// a dropped result carries neither mask nor flood
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[9:0] == 10'd1 << 8))
		else $error("dropped result with mask or flood set");

	// an accepted header is in stage 1 on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted header lost");

	// stage 1 only moves on when the result register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(tag_s1)))
		else $error("stalled header disturbed");
`endif

endmodule

>>> tb/learning_switch_forwarder_core_tb.sv
// ----------------------------------------------------------------------------
// learning_switch_forwarder_core_tb
// Self-checking bench for the learning bridge forwarder.
//
// Header beats go in on s_axis in bursts with random gaps. Decision beats are
// taken off m_axis against a shifting stall pattern, with one long hold-off
// that backs the pipe up. A scoreboard keeps its own address table and
// register copy and predicts every decision in beat order. Registers are
// rewritten between phases once the pipe has drained: a short directed run
// first, then six random phases that include the register extremes.
// ----------------------------------------------------------------------------
module learning_switch_forwarder_core_tb;
	import lsf_pkg::*;

	localparam int                 PHASE_ITEMS    = 325;
	localparam int                 NUM_PHASES     = 6;
	localparam int                 WATCHDOG_LIMIT = 5000;
	localparam int                 LONG_HOLD      = 300;
	localparam int                 SETTLE_CYCLES  = 6;
	localparam logic [IDX_W-1:0]   REG_UNUSED     = 2'd3;

	typedef struct packed {
		logic [TAG_W-1:0]   packet_tag;
		logic [NADDR_W-1:0] dst_addr;
		logic [NADDR_W-1:0] src_addr;
		logic [PORT_W-1:0]  in_port;
	} header_t;

	typedef struct packed {
		logic [TAG_W-1:0]  out_tag;
		logic              was_flooded;
		logic              dropped;
		logic [MASK_W-1:0] forward_mask;
	} decision_t;

	class fwd_scoreboard;
		entry_t            addr_table[ADDR_COUNT];
		cfg_t              cfg;
		logic [MASK_W-1:0] present_ports;
		decision_t         pending_decisions[$];
		int                errors;

		function new();
			foreach (addr_table[i]) addr_table[i] = '0;
			cfg.port_enable   = 8'hFF;
			cfg.min_host_addr = '0;
			cfg.no_learn_addr = NO_LEARN_RESET;
			present_ports     = '0;
			for (int p = 0; p < MASK_W; p++) present_ports[p] = (p < NUM_PORTS);
			errors = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CDATA_W-1:0] data);
			case (idx)
				REG_PORT_ENABLE:   cfg.port_enable   = data[MASK_W-1:0];
				REG_MIN_HOST_ADDR: cfg.min_host_addr = data;
				REG_NO_LEARN_ADDR: cfg.no_learn_addr = data;
				default: ;
			endcase
		endfunction

		// learn first, then look up, so a packet to its own sender turns back
		function void note_header(header_t h);
			decision_t d;
			d = '0;
			d.out_tag = h.packet_tag;
			if (h.src_addr < cfg.min_host_addr) begin
				d.dropped = 1'b1;
			end else begin
				if (h.src_addr != cfg.no_learn_addr && int'(h.src_addr) < ADDR_COUNT &&
				    int'(h.in_port) < NUM_PORTS) begin
					addr_table[h.src_addr].vld  = 1'b1;
					addr_table[h.src_addr].port = h.in_port;
				end
				if (int'(h.dst_addr) < ADDR_COUNT && addr_table[h.dst_addr].vld) begin
					d.forward_mask = MASK_W'(1) << addr_table[h.dst_addr].port;
				end else begin
					d.was_flooded  = 1'b1;
					d.forward_mask = cfg.port_enable & present_ports &
					                 ~(MASK_W'(1) << h.in_port);
				end
			end
			pending_decisions.push_back(d);
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			$display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
			errors++;
		endfunction

		function void check_decision(logic [31:0] beat);
			decision_t got;
			decision_t want;
			got = decision_t'(beat[$bits(decision_t)-1:0]);
			if (pending_decisions.size() == 0) begin
				$display("%0t: unexpected beat, expected none actual %h", $time, beat);
				errors++;
				return;
			end
			want = pending_decisions.pop_front();
			if (got.forward_mask !== want.forward_mask)
				report("forward_mask", 32'(want.forward_mask), 32'(got.forward_mask));
			if (got.dropped !== want.dropped)
				report("dropped", 32'(want.dropped), 32'(got.dropped));
			if (got.was_flooded !== want.was_flooded)
				report("was_flooded", 32'(want.was_flooded), 32'(got.was_flooded));
			if (got.out_tag !== want.out_tag)
				report("out_tag", 32'(want.out_tag), 32'(got.out_tag));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [39:0]         s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [31:0]         m_axis_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [CDATA_W-1:0]  cfg_data;

	fwd_scoreboard sb;
	logic          long_hold_req;
	int            hold_left;
	int            rx_cycle;
	int            idle_cycles;
	int            pool_base;

	learning_switch_forwarder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: stall pattern steps through four modes in turn; long hold on request
	initial begin
		m_axis_tready = 1'b0;
		hold_left     = 0;
		rx_cycle      = 0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = LONG_HOLD - 1;
				m_axis_tready = 1'b0;
			end else begin
				case ((rx_cycle / 97) % 4)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = ($urandom_range(0, 3) != 0);
					2: m_axis_tready = ((rx_cycle % 5) < 3);
					default: m_axis_tready = ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_decision(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// valid is left high on return so back-to-back beats need no gap
	task automatic send_header(header_t h);
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {1'b0, h};
		forever begin
			@(posedge clk);
			if (s_axis_tready) break;
		end
		sb.note_header(h);
	endtask

	task automatic idle_sender(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			s_axis_tdata  = 40'({$urandom, $urandom});
		end
	endtask

	task automatic drain_results();
		idle_sender(1);
		while (sb.pending_decisions.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CDATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// upper data bits of the port_enable write are don't-care, so randomise them
	task automatic configure(logic [MASK_W-1:0] pe, logic [NADDR_W-1:0] min_host,
	                         logic [NADDR_W-1:0] no_learn);
		drain_results();
		write_reg(REG_PORT_ENABLE, {2'($urandom), pe});
		write_reg(REG_UNUSED, CDATA_W'($urandom));
		write_reg(REG_MIN_HOST_ADDR, min_host);
		write_reg(REG_NO_LEARN_ADDR, no_learn);
	endtask

	function automatic header_t hdr(int port, int src, int dst, int tag);
		header_t h;
		h.in_port    = PORT_W'(port);
		h.src_addr   = NADDR_W'(src);
		h.dst_addr   = NADDR_W'(dst);
		h.packet_tag = TAG_W'(tag);
		return h;
	endfunction

	// mostly a small pool so destinations get learned; some edge and wide values
	function automatic header_t random_header();
		header_t h;
		int      r;
		h.in_port    = PORT_W'($urandom_range(0, 7));
		h.packet_tag = TAG_W'($urandom);
		r = $urandom_range(0, 99);
		if (r < 70)
			h.src_addr = NADDR_W'(pool_base + $urandom_range(0, 15));
		else if (r < 78)
			h.src_addr = sb.cfg.min_host_addr - NADDR_W'($urandom_range(0, 1));
		else if (r < 86)
			h.src_addr = sb.cfg.no_learn_addr;
		else
			h.src_addr = NADDR_W'($urandom);
		if ($urandom_range(0, 3) != 0)
			h.dst_addr = NADDR_W'(pool_base + $urandom_range(0, 15));
		else
			h.dst_addr = NADDR_W'($urandom);
		return h;
	endfunction

	initial begin
		int sent;
		int burst;
		int min_host;

		sb            = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		long_hold_req = 1'b0;
		idle_cycles   = 0;
		pool_base     = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: learning, own-sender turn-back, no-learn source, extremes
		send_header(hdr(0, 5, 7, 16'h0000));
		send_header(hdr(7, 7, 5, 16'hFFFF));
		send_header(hdr(3, 20, 20, 16'h1234));
		send_header(hdr(2, 1000, 1000, 16'hA5A5));
		send_header(hdr(1, 1023, 0, 16'h5A5A));
		send_header(hdr(6, 0, 1023, 16'h8001));
		send_header(hdr(5, 7, 7, 16'h7FFE));
		send_header(hdr(0, 3, 7, 16'h0F0F));

		// all ports disabled: drops, empty flood, known port still used
		configure(8'h00, 10, 3);
		send_header(hdr(4, 9, 5, 16'h0001));
		send_header(hdr(4, 10, 11, 16'h0002));
		send_header(hdr(2, 12, 7, 16'h0003));
		send_header(hdr(1, 3, 3, 16'h0004));
		send_header(hdr(3, 0, 0, 16'h0005));

		configure(8'h81, 1023, 1023);
		send_header(hdr(0, 1022, 5, 16'h0006));
		send_header(hdr(7, 1023, 20, 16'h0007));
		send_header(hdr(7, 1023, 1022, 16'h0008));

		// only the input port enabled: flood leaves nothing
		configure(8'h80, 0, 1000);
		send_header(hdr(7, 30, 31, 16'h0009));
		send_header(hdr(7, 31, 30, 16'h000A));

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: configure(8'hFF, 0, 0);
				1: configure(8'h00, 1023, 1023);
				default: begin
					min_host = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
					                                       : $urandom_range(0, 96);
					configure(MASK_W'($urandom), NADDR_W'(min_host), NADDR_W'($urandom));
				end
			endcase
			min_host  = sb.cfg.min_host_addr;
			pool_base = (min_host > 1008) ? 1008 : $urandom_range(min_host, 1008);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 48);
				for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
					send_header(random_header());
					sent++;
					if (phase == 2 && sent == 100)
						long_hold_req = 1'b1;
					if (phase == 3 && sent == PHASE_ITEMS / 2)
						drain_results();
				end
				if ($urandom_range(0, 3) != 0)
					idle_sender($urandom_range(1, 12));
			end
		end

		drain_results();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
